// ----- rtl/wpsu_pkg.sv -----
// shared types and constants for the widest path search unit
`timescale 1ns / 1ps

package wpsu_pkg;

	localparam int VTX_W = 9;
	localparam int BW_W = 32;
	localparam int ACT_W = 2;

	// vertex numbers are VTX_W bits wide, enough to name vertices 1 to MAX_VERTICES
	localparam int MAX_VERTICES = 256;

	localparam logic [VTX_W-1:0] VCOUNT_RESET = 9'd256;
	localparam logic [BW_W-1:0] WIDTH_INF = '1;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		MARK_UNSEEN = 2'd0,
		MARK_FRINGE = 2'd1,
		MARK_TREE   = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		RES_NONE  = 2'd0,
		RES_SELF  = 2'd1,
		RES_FOUND = 2'd2
	} res_kind_t;

	typedef struct packed {
		logic [VTX_W-1:0] tail;
		logic [VTX_W-1:0] head;
		logic [BW_W-1:0]  bw;
	} arc_t;

	typedef struct packed {
		mark_t           mark;
		logic [BW_W-1:0] width;
	} vent_t;

	typedef struct packed {
		logic      clear_graph;
		logic      add_arc;
		logic      q_load;
		logic      clr_step;
		logic      seed;
		logic      arc_read;
		logic      arc_next;
		logic      vtx_read;
		logic      vtx_update;
		logic      sel_start;
		logic      pick;
		logic      out_load;
		res_kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic query_ok;
		logic same_vertex;
		logic clr_last;
		logic arc_none;
		logic arc_last;
		logic arc_hit;
		logic sel_busy;
		logic found;
		logic pick_is_dst;
	} dp_stat_t;

endpackage

// ----- rtl/wpsu_dp.sv -----
// datapath: arc store, vertex store, relaxation and fringe selection
`timescale 1ns / 1ps

module wpsu_dp #(
	parameter int MAX_ARCS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [wpsu_pkg::VTX_W-1:0] cfg_write_data,
	input  logic [wpsu_pkg::VTX_W-1:0] from_vertex,
	input  logic [wpsu_pkg::VTX_W-1:0] to_vertex,
	input  logic [wpsu_pkg::BW_W-1:0]  arc_width,
	input  wpsu_pkg::dp_cmd_t          cmd,
	output wpsu_pkg::dp_stat_t         stat,
	output logic [wpsu_pkg::BW_W-1:0]  best_width,
	output logic                       reachable,
	output logic                       arcs_dropped
);
	import wpsu_pkg::*;

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int VNW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (VNW > VTX_W) ? VNW : VTX_W;
	localparam int AAW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
	localparam int ATW = $clog2(MAX_ARCS + 1);
	localparam logic [CW-1:0] NMAX = CW'(MAX_VERTICES);
	localparam logic [ATW-1:0] ACAP = ATW'(MAX_ARCS);

	logic [VTX_W-1:0] vcount_q;
	logic [ATW-1:0]   arc_total_q;
	logic             overflow_q;
	logic [VTX_W-1:0] src_q, dst_q, cur_q;
	logic [BW_W-1:0]  curw_q;
	logic [CW-1:0]    n_q, n_clamp;
	logic [VAW-1:0]   sweep_q;
	logic [AAW-1:0]   arc_idx_q;

	arc_t  arc_mem [MAX_ARCS];
	arc_t  arc_rd_q;
	vent_t vtx_mem [MAX_VERTICES];
	vent_t vtx_rd_q;

	logic [VAW-1:0] sel_ptr_q, sel_idx_s1, pick_q;
	logic           sel_issue_q, sel_v_s1, found_q;
	logic [BW_W-1:0] best_q;

	logic           vw_en, vr_en;
	logic [VAW-1:0] vw_addr, vr_addr, head_addr;
	vent_t          vw_data;
	logic [BW_W-1:0] cand;

	function automatic logic in_range(input logic [VTX_W-1:0] v, input logic [CW-1:0] n);
		return (v != '0) && (CW'(v) <= n);
	endfunction

	function automatic logic [VAW-1:0] vaddr(input logic [VTX_W-1:0] v);
		logic [VTX_W-1:0] d;
		d = v - 1'b1;
		return VAW'(d);
	endfunction

	always_comb begin
		if (vcount_q == '0) begin
			n_clamp = CW'(1);
		end else if (CW'(vcount_q) > NMAX) begin
			n_clamp = NMAX;
		end else begin
			n_clamp = CW'(vcount_q);
		end
	end

	assign head_addr = vaddr(arc_rd_q.head);
	assign cand = (arc_rd_q.bw < curw_q) ? arc_rd_q.bw : curw_q;

	assign stat.query_ok = in_range(src_q, n_q) && in_range(dst_q, n_q);
	assign stat.same_vertex = (src_q == dst_q);
	assign stat.clr_last = (CW'(sweep_q) == n_q - 1'b1);
	assign stat.arc_none = (arc_total_q == '0);
	assign stat.arc_last = (ATW'(arc_idx_q) == arc_total_q - 1'b1);
	assign stat.arc_hit = (arc_rd_q.tail == cur_q) && in_range(arc_rd_q.head, n_q);
	assign stat.sel_busy = sel_issue_q | sel_v_s1;
	assign stat.found = found_q;
	assign stat.pick_is_dst = found_q && (pick_q == vaddr(dst_q));

	// vertex store write port
	always_comb begin
		vw_en = 1'b0;
		vw_addr = sweep_q;
		vw_data = '{mark: MARK_UNSEEN, width: '0};
		if (cmd.clr_step) begin
			vw_en = 1'b1;
		end else if (cmd.seed) begin
			vw_en = 1'b1;
			vw_addr = vaddr(src_q);
			vw_data = '{mark: MARK_TREE, width: WIDTH_INF};
		end else if (cmd.vtx_update) begin
			vw_addr = head_addr;
			vw_data = '{mark: MARK_FRINGE, width: cand};
			vw_en = (vtx_rd_q.mark == MARK_UNSEEN) ||
				((vtx_rd_q.mark == MARK_FRINGE) && (vtx_rd_q.width < cand));
		end else if (cmd.pick) begin
			vw_en = found_q;
			vw_addr = pick_q;
			vw_data = '{mark: MARK_TREE, width: best_q};
		end
	end

	assign vr_en = cmd.vtx_read | sel_issue_q;
	assign vr_addr = cmd.vtx_read ? head_addr : sel_ptr_q;

	always_ff @(posedge clk) begin
		if (vw_en) vtx_mem[vw_addr] <= vw_data;
		if (vr_en) vtx_rd_q <= vtx_mem[vr_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_arc && (arc_total_q < ACAP)) begin
			arc_mem[AAW'(arc_total_q)] <= '{tail: from_vertex, head: to_vertex, bw: arc_width};
		end
		if (cmd.arc_read) arc_rd_q <= arc_mem[arc_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
			arc_total_q <= '0;
			overflow_q <= 1'b0;
			sel_issue_q <= 1'b0;
			sel_v_s1 <= 1'b0;
		end else begin
			if (cfg_write_en) vcount_q <= cfg_write_data;
			if (cmd.clear_graph) begin
				arc_total_q <= '0;
				overflow_q <= 1'b0;
			end else if (cmd.add_arc) begin
				if (arc_total_q < ACAP) arc_total_q <= arc_total_q + 1'b1;
				else overflow_q <= 1'b1;
			end
			if (cmd.sel_start) begin
				sel_issue_q <= 1'b1;
			end else if (sel_issue_q && (CW'(sel_ptr_q) == n_q - 1'b1)) begin
				sel_issue_q <= 1'b0;
			end
			sel_v_s1 <= sel_issue_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			src_q <= from_vertex;
			dst_q <= to_vertex;
			n_q <= n_clamp;
			sweep_q <= '0;
		end
		if (cmd.clr_step) sweep_q <= sweep_q + 1'b1;
		if (cmd.seed) begin
			cur_q <= src_q;
			curw_q <= WIDTH_INF;
			arc_idx_q <= '0;
		end else if (cmd.pick) begin
			cur_q <= VTX_W'(pick_q) + 1'b1;
			curw_q <= best_q;
			arc_idx_q <= '0;
		end else if (cmd.arc_next) begin
			arc_idx_q <= arc_idx_q + 1'b1;
		end
		// fringe scan: address issue, then compare in the following cycle
		if (cmd.sel_start) begin
			sel_ptr_q <= '0;
			found_q <= 1'b0;
		end else if (sel_issue_q) begin
			sel_ptr_q <= sel_ptr_q + 1'b1;
		end
		sel_idx_s1 <= sel_ptr_q;
		if (sel_v_s1 && (vtx_rd_q.mark == MARK_FRINGE) &&
			(!found_q || (vtx_rd_q.width > best_q))) begin
			found_q <= 1'b1;
			best_q <= vtx_rd_q.width;
			pick_q <= sel_idx_s1;
		end
		if (cmd.out_load) begin
			arcs_dropped <= overflow_q;
			unique case (cmd.res_kind)
				RES_SELF: begin
					best_width <= WIDTH_INF;
					reachable <= 1'b1;
				end
				RES_FOUND: begin
					best_width <= best_q;
					reachable <= 1'b1;
				end
				default: begin
					best_width <= '0;
					reachable <= 1'b0;
				end
			endcase
		end
	end

	a_vtx_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vw_en |-> (CW'(vw_addr) < n_q))
		else $error("vertex write beyond vertex count");
	a_arc_rd_stored: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.arc_read |-> (ATW'(arc_idx_q) < arc_total_q))
		else $error("arc read beyond stored arcs");
	a_pick_not_src: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pick && found_q) |-> (pick_q != vaddr(src_q)))
		else $error("source picked from fringe");

endmodule

// ----- rtl/wpsu_ctrl.sv -----
// controller: sequences clear, relaxation and fringe scan for each query that needs a search
`timescale 1ns / 1ps

module wpsu_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [wpsu_pkg::ACT_W-1:0] action,
	output logic                       out_valid,
	input  logic                       out_stall,
	output wpsu_pkg::dp_cmd_t          cmd,
	input  wpsu_pkg::dp_stat_t         stat
);
	import wpsu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_CLEAR, ST_SEED, ST_ARC_RD, ST_ARC_CHK,
		ST_VTX_UPD, ST_SEL_START, ST_SEL_RUN, ST_PICK, ST_FINISH
	} state_t;

	state_t    state_q, state_d;
	res_kind_t res_kind_q, res_kind_d;
	logic      out_valid_q;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.res_kind = res_kind_q;
		state_d = state_q;
		res_kind_d = res_kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (action)
						ACT_CLEAR: cmd.clear_graph = 1'b1;
						ACT_ADD:   cmd.add_arc = 1'b1;
						ACT_QUERY: begin
							cmd.q_load = 1'b1;
							state_d = ST_CHECK;
						end
						default: ;
					endcase
				end
			end
			ST_CHECK: begin
				if (!stat.query_ok) begin
					res_kind_d = RES_NONE;
					state_d = ST_FINISH;
				end else if (stat.same_vertex) begin
					res_kind_d = RES_SELF;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = ST_SEED;
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d = stat.arc_none ? ST_SEL_START : ST_ARC_RD;
			end
			ST_ARC_RD: begin
				cmd.arc_read = 1'b1;
				state_d = ST_ARC_CHK;
			end
			ST_ARC_CHK: begin
				if (stat.arc_hit) begin
					cmd.vtx_read = 1'b1;
					state_d = ST_VTX_UPD;
				end else begin
					cmd.arc_next = 1'b1;
					state_d = stat.arc_last ? ST_SEL_START : ST_ARC_RD;
				end
			end
			ST_VTX_UPD: begin
				cmd.vtx_update = 1'b1;
				cmd.arc_next = 1'b1;
				state_d = stat.arc_last ? ST_SEL_START : ST_ARC_RD;
			end
			ST_SEL_START: begin
				cmd.sel_start = 1'b1;
				state_d = ST_SEL_RUN;
			end
			ST_SEL_RUN: begin
				if (!stat.sel_busy) state_d = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				if (!stat.found) begin
					res_kind_d = RES_NONE;
					state_d = ST_FINISH;
				end else if (stat.pick_is_dst) begin
					res_kind_d = RES_FOUND;
					state_d = ST_FINISH;
				end else begin
					state_d = stat.arc_none ? ST_SEL_START : ST_ARC_RD;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_kind_q <= RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_kind_q <= res_kind_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/widest_path_search_unit.sv -----
// Widest path search unit: arc store plus array-based maximum-bandwidth path search.
// Clear and add-arc items are taken while idle and may follow back to back; an added
// arc beyond MAX_ARCS is dropped and flagged. A query first resets the marks of all
// n vertices (n = vertex count), then for every vertex moved into the tree makes one
// pass over all stored arcs (each arc read and checked, and its head vertex updated
// where the arc leaves that vertex) and one fringe scan over the vertex store to pick
// the widest fringe vertex. Source equal to destination, or an endpoint outside the
// vertex count, answers without a search. Results leave through an output register,
// so the next item is taken while a result waits for its transfer.
`timescale 1ns / 1ps

module widest_path_search_unit #(
	parameter int MAX_ARCS = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [wpsu_pkg::VTX_W-1:0] cfg_write_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [wpsu_pkg::ACT_W-1:0] action,
	input  logic [wpsu_pkg::VTX_W-1:0] from_vertex,
	input  logic [wpsu_pkg::VTX_W-1:0] to_vertex,
	input  logic [wpsu_pkg::BW_W-1:0]  arc_width,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [wpsu_pkg::BW_W-1:0]  best_width,
	output logic                       reachable,
	output logic                       arcs_dropped
);
	import wpsu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	wpsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	wpsu_dp #(
		.MAX_ARCS     (MAX_ARCS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.from_vertex    (from_vertex),
		.to_vertex      (to_vertex),
		.arc_width      (arc_width),
		.cmd            (cmd),
		.stat           (stat),
		.best_width     (best_width),
		.reachable      (reachable),
		.arcs_dropped   (arcs_dropped)
	);

endmodule

// ----- tb/sv/widest_path_checker.sv -----
// checker for the widest path search unit: watches both channels, predicts and compares
`timescale 1ns / 1ps

module widest_path_checker
	import wpsu_pkg::*;
#(
	parameter int MAX_ARCS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [VTX_W-1:0] cfg_write_data,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [ACT_W-1:0] action,
	input  logic [VTX_W-1:0] from_vertex,
	input  logic [VTX_W-1:0] to_vertex,
	input  logic [BW_W-1:0]  arc_width,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [BW_W-1:0]  best_width,
	input  logic             reachable,
	input  logic             arcs_dropped,
	output int               pending,
	output int               errors
);

	typedef struct {
		logic [BW_W-1:0] bw;
		logic            ok;
		logic            dropped;
	} answer_t;

	logic [VTX_W-1:0] arc_tail [0:MAX_ARCS-1];
	logic [VTX_W-1:0] arc_head [0:MAX_ARCS-1];
	logic [BW_W-1:0]  arc_bw [0:MAX_ARCS-1];
	int               arc_count;
	logic             store_overflow;
	logic [VTX_W-1:0] vertex_count;
	answer_t          answers_due[$];

	assign pending = answers_due.size();

	function automatic int vertices_in_use();
		if (vertex_count < 1) return 1;
		if (vertex_count > MAX_VERTICES) return MAX_VERTICES;
		return int'(vertex_count);
	endfunction

	// array dijkstra for the maximum bottleneck path
	function automatic answer_t widest_path(input logic [VTX_W-1:0] src,
			input logic [VTX_W-1:0] dst);
		answer_t         ans;
		mark_t           mark [0:MAX_VERTICES];
		logic [BW_W-1:0] wd [0:MAX_VERTICES];
		logic [BW_W-1:0] cand;
		logic [BW_W-1:0] best;
		int              n;
		int              v;
		int              h;
		int              pick;
		bit              found;
		n = vertices_in_use();
		ans.bw = '0;
		ans.ok = 1'b0;
		ans.dropped = store_overflow;
		if (src < 1 || src > n || dst < 1 || dst > n) return ans;
		if (src == dst) begin
			ans.bw = WIDTH_INF;
			ans.ok = 1'b1;
			return ans;
		end
		for (int i = 0; i <= n; i++) mark[i] = MARK_UNSEEN;
		mark[src] = MARK_TREE;
		wd[src] = WIDTH_INF;
		v = src;
		forever begin
			for (int i = 0; i < arc_count; i++) begin
				h = int'(arc_head[i]);
				if (arc_tail[i] == v && h >= 1 && h <= n) begin
					cand = (arc_bw[i] < wd[v]) ? arc_bw[i] : wd[v];
					if (mark[h] == MARK_UNSEEN) begin
						mark[h] = MARK_FRINGE;
						wd[h] = cand;
					end else if (mark[h] == MARK_FRINGE && wd[h] < cand) begin
						wd[h] = cand;
					end
				end
			end
			found = 0;
			best = '0;
			pick = 0;
			for (int i = 1; i <= n; i++) begin
				if (mark[i] == MARK_FRINGE && (!found || wd[i] > best)) begin
					found = 1;
					best = wd[i];
					pick = i;
				end
			end
			if (!found) return ans;
			mark[pick] = MARK_TREE;
			if (pick == dst) begin
				ans.bw = wd[dst];
				ans.ok = 1'b1;
				return ans;
			end
			v = pick;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			arc_count = 0;
			store_overflow = 1'b0;
			vertex_count = VCOUNT_RESET;
			answers_due.delete();
			errors = 0;
		end else begin
			if (cfg_write_en) vertex_count = cfg_write_data;
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t unexpected result: width %h reach %b dropped %b",
							$realtime, best_width, reachable, arcs_dropped);
				end else begin
					want = answers_due.pop_front();
					if (best_width !== want.bw || reachable !== want.ok
							|| arcs_dropped !== want.dropped) begin
						errors++;
						if (errors <= 10)
							$display("%0t mismatch: width %h/%h reach %b/%b dropped %b/%b",
								$realtime, best_width, want.bw, reachable, want.ok,
								arcs_dropped, want.dropped);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (action)
					ACT_CLEAR: begin
						arc_count = 0;
						store_overflow = 1'b0;
					end
					ACT_ADD: begin
						if (arc_count < MAX_ARCS) begin
							arc_tail[arc_count] = from_vertex;
							arc_head[arc_count] = to_vertex;
							arc_bw[arc_count] = arc_width;
							arc_count++;
						end else begin
							store_overflow = 1'b1;
						end
					end
					ACT_QUERY: answers_due.push_back(widest_path(from_vertex, to_vertex));
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// top of the widest path search unit testbench: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module testbench;
	import wpsu_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 20_000_000;

	logic             clk;
	logic             arst_n;
	logic             cfg_write_en;
	logic [VTX_W-1:0] cfg_write_data;
	logic             in_valid;
	logic             in_stall;
	logic [ACT_W-1:0] action;
	logic [VTX_W-1:0] from_vertex;
	logic [VTX_W-1:0] to_vertex;
	logic [BW_W-1:0]  arc_width;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [BW_W-1:0]  best_width;
	logic             reachable;
	logic             arcs_dropped;
	int               pending;
	int               errors;
	bit               calm;
	longint           cycles = 0;

	widest_path_search_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .from_vertex(from_vertex), .to_vertex(to_vertex),
		.arc_width(arc_width),
		.out_valid(out_valid), .out_stall(out_stall),
		.best_width(best_width), .reachable(reachable), .arcs_dropped(arcs_dropped)
	);

	widest_path_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .from_vertex(from_vertex), .to_vertex(to_vertex),
		.arc_width(arc_width),
		.out_valid(out_valid), .out_stall(out_stall),
		.best_width(best_width), .reachable(reachable), .arcs_dropped(arcs_dropped),
		.pending(pending), .errors(errors)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= !calm && ($urandom_range(99) < 10);
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic [ACT_W-1:0] a, input logic [VTX_W-1:0] f,
			input logic [VTX_W-1:0] t, input logic [BW_W-1:0] w);
		bit taken;
		while (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		from_vertex <= f;
		to_vertex <= t;
		arc_width <= w;
		taken = 0;
		// stall is settled by the falling edge, it is the value seen at the next transfer
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
	endtask

	task automatic settle_and_write(input logic [VTX_W-1:0] vc);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= vc;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [VTX_W-1:0] some_vertex(input int n);
		if ($urandom_range(99) < 85) return VTX_W'($urandom_range(n, 1));
		return VTX_W'($urandom_range(511, 0));
	endfunction

	function automatic logic [BW_W-1:0] some_width();
		case ($urandom_range(3))
			0: return $urandom_range(3, 0);
			1: return WIDTH_INF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input logic [VTX_W-1:0] vc, input int sets);
		int n;
		int arcs;
		logic [VTX_W-1:0] src;
		n = (vc < 1) ? 1 : (vc > MAX_VERTICES) ? MAX_VERTICES : int'(vc);
		settle_and_write(vc);
		repeat (sets) begin
			if ($urandom_range(99) < 80)
				send_item(ACT_CLEAR, VTX_W'($urandom), VTX_W'($urandom), $urandom);
			arcs = $urandom_range(24, 0);
			repeat (arcs) begin
				if ($urandom_range(99) < 4)
					send_item(ACT_UNUSED, VTX_W'($urandom), VTX_W'($urandom), $urandom);
				send_item(ACT_ADD, some_vertex(n), some_vertex(n), some_width());
			end
			repeat ($urandom_range(4, 1)) begin
				src = some_vertex(n);
				if ($urandom_range(99) < 8) send_item(ACT_QUERY, src, src, $urandom);
				else send_item(ACT_QUERY, src, some_vertex(n), $urandom);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		in_valid = 1'b0;
		action = ACT_CLEAR;
		from_vertex = '0;
		to_vertex = '0;
		arc_width = '0;
		calm = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty graph, range limits, ignored code, parallel arcs, ties, zero width
		send_item(ACT_QUERY, 9'd1, 9'd1, '0);
		send_item(ACT_QUERY, 9'd1, 9'd2, '0);
		send_item(ACT_QUERY, 9'd0, 9'd1, '0);
		send_item(ACT_QUERY, 9'd1, 9'd257, '0);
		send_item(ACT_UNUSED, 9'd1, 9'd2, '1);
		send_item(ACT_ADD, 9'd1, 9'd2, WIDTH_INF);
		send_item(ACT_ADD, 9'd1, 9'd2, 32'd5);
		send_item(ACT_ADD, 9'd2, 9'd3, 32'd0);
		send_item(ACT_ADD, 9'd3, 9'd1, 32'd7);
		send_item(ACT_ADD, 9'd1, 9'd4, 32'd10);
		send_item(ACT_ADD, 9'd1, 9'd5, 32'd10);
		send_item(ACT_ADD, 9'd4, 9'd6, 32'd3);
		send_item(ACT_ADD, 9'd5, 9'd6, 32'd4);
		send_item(ACT_ADD, 9'd300, 9'd6, 32'd99);
		send_item(ACT_ADD, 9'd6, 9'd511, 32'hA5A5_5A5A);
		send_item(ACT_QUERY, 9'd1, 9'd2, '0);
		send_item(ACT_QUERY, 9'd1, 9'd3, '0);
		send_item(ACT_QUERY, 9'd1, 9'd6, '0);
		send_item(ACT_QUERY, 9'd1, 9'd7, '0);
		send_item(ACT_QUERY, 9'd256, 9'd256, '0);
		send_item(ACT_CLEAR, '1, '1, '1);
		send_item(ACT_QUERY, 9'd1, 9'd2, '0);

		random_phase(9'd1, 10);
		random_phase(9'd2, 10);
		random_phase(9'd3, 10);
		calm = 1;
		random_phase(9'd5, 10);
		calm = 0;
		random_phase(9'd8, 10);
		random_phase(9'd0, 10);
		random_phase(9'd300, 3);
		random_phase(9'd16, 10);
		random_phase(9'd511, 3);
		random_phase(9'd64, 4);
		random_phase(9'd12, 10);
		random_phase(9'd6, 8);

		random_phase(VCOUNT_RESET, 3);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
